>>> rtl/rssa_pkg.sv
package rssa_pkg;

	// Largest sweep the block is built for by default.
	localparam int unsigned MAX_CHANNELS_DEF = 128;

	// The slot travels in an eight-bit field, which covers any sweep up to 256 slots.
	localparam int unsigned SLOT_FIELD_W = 8;

	// One store entry holds the smoothed level above the peak level.
	localparam int unsigned LEVEL_W = 8;
	localparam int unsigned STORE_W = 2 * LEVEL_W;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 2;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_FIRST_CHANNEL  = 2'd0;
	localparam cfg_idx_t REG_LAST_CHANNEL   = 2'd1;
	localparam cfg_idx_t REG_SAMPLE_SETTING = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [7:0] FIRST_CHANNEL_RST  = 8'd0;
	localparam logic [7:0] LAST_CHANNEL_RST   = 8'd127;
	localparam logic [7:0] SAMPLE_SETTING_RST = 8'd0;

	// Top bit of the raw level, flipped to turn two's complement into an offset level.
	localparam logic [7:0] LEVEL_OFFSET = 8'h80;

	// Division by ten of a value below 2560: multiply by 3277 and drop 15 bits.
	localparam int unsigned SUM_W       = 12;
	localparam logic [11:0] RECIP_TEN   = 12'd3277;
	localparam int unsigned RECIP_SHIFT = 15;
	localparam int unsigned PROD_W      = 2 * SUM_W;

	typedef struct packed {
		logic [7:0] raw_level;
	} in_word_t;

	typedef struct packed {
		logic       retune;
		logic [6:0] slot_index;
		logic [7:0] radio_channel;
		logic [7:0] smoothed_level;
		logic [7:0] peak_level;
		logic       dwell_done;
		logic       sweep_wrapped;
	} out_word_t;

	typedef struct packed {
		cfg_idx_t   index;
		logic [7:0] data;
	} cfg_word_t;

	// What the sequencer decides for one tick, handed to the datapath.
	typedef struct packed {
		logic                    retune;
		logic                    done;
		logic                    wrapped;
		logic                    clear_peak;
		logic [SLOT_FIELD_W-1:0] slot;
		logic [7:0]              channel;
	} tick_t;

endpackage

>>> rtl/rssa_if.sv
interface rssa_in_if import rssa_pkg::*; ();
	logic     valid;
	logic     ready;
	in_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rssa_out_if import rssa_pkg::*; ();
	logic      valid;
	logic      ready;
	out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rssa_cfg_if import rssa_pkg::*; ();
	logic      valid;
	logic      ready;
	cfg_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/rssa_ram.sv
module rssa_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/rssa_ctrl.sv
module rssa_ctrl import rssa_pkg::*; #(
	parameter int unsigned MAX_CHANNELS = MAX_CHANNELS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	rssa_cfg_if.sink cfg,
	input  logic accept,
	output tick_t tick
);

	localparam int unsigned SLOT_W = $clog2(MAX_CHANNELS);

	logic [7:0]        first_q;
	logic [7:0]        last_q;
	logic [7:0]        setting_q;
	logic              phase_q;
	logic [SLOT_W-1:0] slot_q;
	logic [7:0]        count_q;

	logic signed [9:0] diff;
	logic [9:0]        span;
	logic [SLOT_W:0]   slot_inc;
	logic              wrap;
	logic [SLOT_W-1:0] slot_new;
	logic [7:0]        mag;
	logic [7:0]        limit;
	logic [7:0]        count_inc;
	logic              done;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q   <= FIRST_CHANNEL_RST;
			last_q    <= LAST_CHANNEL_RST;
			setting_q <= SAMPLE_SETTING_RST;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				REG_FIRST_CHANNEL:  first_q   <= cfg.data.data;
				REG_LAST_CHANNEL:   last_q    <= cfg.data.data;
				REG_SAMPLE_SETTING: setting_q <= cfg.data.data;
				default: ;
			endcase
		end
	end

	// The span is clamped to at least one slot and at most the store depth.
	always_comb begin
		diff = $signed({2'b00, last_q}) - $signed({2'b00, first_q}) + 10'sd1;
		if (diff < 10'sd1) begin
			span = 10'd1;
		end else if (diff > $signed(10'(MAX_CHANNELS))) begin
			span = 10'(MAX_CHANNELS);
		end else begin
			span = 10'(diff);
		end
	end

	// A setting of 0x80 has a magnitude of 128, which fits the unsigned byte.
	assign mag       = setting_q[7] ? 8'(-setting_q) : setting_q;
	assign limit     = (mag == 8'd0) ? 8'd1 : mag;
	assign count_inc = count_q + 8'd1;

	assign slot_inc = {1'b0, slot_q} + (SLOT_W + 1)'(1);
	assign wrap     = (10'(slot_inc) >= span);
	assign done     = phase_q && (count_inc >= limit);

	always_comb begin
		if (!phase_q) begin
			slot_new = wrap ? '0 : slot_inc[SLOT_W-1:0];
		end else begin
			slot_new = slot_q;
		end
	end

	always_comb begin
		tick.retune     = !phase_q;
		tick.done       = done;
		tick.wrapped    = !phase_q && wrap;
		tick.clear_peak = !phase_q && (setting_q != 8'd0);
		tick.slot       = SLOT_FIELD_W'(slot_new);
		tick.channel    = first_q + 8'(slot_new);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			slot_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			slot_q <= slot_new;
			if (!phase_q) begin
				phase_q <= 1'b1;
				count_q <= '0;
			end else begin
				phase_q <= !done;
				count_q <= count_inc;
			end
		end
	end

endmodule

>>> rtl/rssa_datapath.sv
module rssa_datapath import rssa_pkg::*; #(
	parameter int unsigned MAX_CHANNELS = MAX_CHANNELS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	rssa_in_if.sink   sample,
	rssa_out_if.source result,
	input  tick_t tick,
	output logic  accept
);

	localparam int unsigned SLOT_W = $clog2(MAX_CHANNELS);

	logic                    valid_s1;
	tick_t                   tick_s1;
	logic [LEVEL_W-1:0]      level_s1;
	logic [SLOT_W-1:0]       slot_s1;
	logic                    adv_s1;

	logic [MAX_CHANNELS-1:0] written_q;
	logic                    fwd_vld_q;
	logic [SLOT_W-1:0]       fwd_slot_q;
	logic [LEVEL_W-1:0]      fwd_avg_q;
	logic [LEVEL_W-1:0]      fwd_peak_q;

	logic                    out_valid_q;
	out_word_t               out_q;

	logic [STORE_W-1:0]      rdata;
	logic                    fwd_hit;
	logic [LEVEL_W-1:0]      old_avg;
	logic [LEVEL_W-1:0]      old_peak;
	logic [SUM_W-1:0]        sum;
	logic [PROD_W-1:0]       prod;
	logic [LEVEL_W-1:0]      new_avg;
	logic [LEVEL_W-1:0]      new_peak;

	// The output register frees the pipeline stage whenever it is empty or the sink takes a word.
	assign adv_s1       = valid_s1 && (!out_valid_q || result.ready);
	assign sample.ready = !valid_s1 || adv_s1;
	assign accept       = sample.valid && sample.ready;
	assign slot_s1      = tick_s1.slot[SLOT_W-1:0];

	rssa_ram #(
		.WIDTH (STORE_W),
		.DEPTH (MAX_CHANNELS)
	) u_store (
		.clk   (clk),
		.we    (adv_s1),
		.waddr (slot_s1),
		.wdata ({new_avg, new_peak}),
		.re    (accept),
		.raddr (tick.slot[SLOT_W-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tick_s1  <= tick;
			level_s1 <= sample.data.raw_level ^ LEVEL_OFFSET;
		end
	end

	// The last write is forwarded, since the next word may have read that entry
	// at the very edge it was written. An entry never written reads as zero.
	assign fwd_hit = fwd_vld_q && (fwd_slot_q == slot_s1);

	always_comb begin
		if (fwd_hit) begin
			old_avg  = fwd_avg_q;
			old_peak = fwd_peak_q;
		end else if (written_q[slot_s1]) begin
			old_avg  = rdata[STORE_W-1:LEVEL_W];
			old_peak = rdata[LEVEL_W-1:0];
		end else begin
			old_avg  = '0;
			old_peak = '0;
		end
	end

	assign sum  = SUM_W'(level_s1) + (SUM_W'(old_avg) << 3) + SUM_W'(old_avg);
	assign prod = PROD_W'(sum) * PROD_W'(RECIP_TEN);

	always_comb begin
		if (tick_s1.retune) begin
			new_avg  = old_avg;
			new_peak = tick_s1.clear_peak ? '0 : old_peak;
		end else begin
			new_avg  = prod[RECIP_SHIFT +: LEVEL_W];
			new_peak = (level_s1 > old_peak) ? level_s1 : old_peak;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			fwd_vld_q <= 1'b0;
		end else if (adv_s1) begin
			written_q[slot_s1] <= 1'b1;
			fwd_vld_q          <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			fwd_slot_q <= slot_s1;
			fwd_avg_q  <= new_avg;
			fwd_peak_q <= new_peak;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_q.retune         <= tick_s1.retune;
			out_q.slot_index     <= tick_s1.slot[6:0];
			out_q.radio_channel  <= tick_s1.channel;
			out_q.smoothed_level <= new_avg;
			out_q.peak_level     <= new_peak;
			out_q.dwell_done     <= tick_s1.done;
			out_q.sweep_wrapped  <= tick_s1.wrapped;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	a_fwd_marks_written: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> fwd_vld_q && written_q[fwd_slot_q])
		else $error("forwarded entry is not marked as written");

	a_retune_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> !(tick_s1.retune && tick_s1.done))
		else $error("a retune word also ends a dwell");

	a_wrap_to_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && tick_s1.wrapped |-> tick_s1.retune && (tick_s1.slot == '0))
		else $error("wrap flagged without a retune to slot zero");

	a_clear_peak: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && tick_s1.retune && tick_s1.clear_peak |=> result.data.peak_level == '0)
		else $error("peak not cleared on retune");

	a_slot_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> ({1'b0, tick_s1.slot} < 9'(MAX_CHANNELS)))
		else $error("slot beyond the store depth");

endmodule

>>> rtl/rssi_sweep_averager.sv
// Channel-sweeping signal strength monitor. Each input word is one timer tick; the block
// alternates between a retune tick, which steps to the next slot of the sweep (wrapping at
// last_channel - first_channel + 1, clamped to 1..MAX_CHANNELS) and reports the radio channel,
// and one or more measure ticks, which fold the offset level into the slot's smoothed level
// (s + 9*old)/10 and its peak hold. Every tick gives exactly one result word. A new word is
// taken every clock cycle as long as the result side takes its words. Each tick passes through
// an input stage (s1) and then the output register, which holds the result word until taken.
// Stage s1 does one registered read and write-back of the per-slot store, with the last write
// forwarded so back-to-back ticks on the same slot see it. The store is clear from reset onward
// through a written flag per slot, so no clearing pass is needed. Configuration writes are
// taken at any time but are meant for when no tick is in flight.
module rssi_sweep_averager import rssa_pkg::*; #(
	parameter int unsigned MAX_CHANNELS = MAX_CHANNELS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	rssa_cfg_if.sink   cfg,
	rssa_in_if.sink    sample,
	rssa_out_if.source result
);

	tick_t tick;
	logic  accept;

	rssa_ctrl #(
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.accept (accept),
		.tick   (tick)
	);

	rssa_datapath #(
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample),
		.result (result),
		.tick   (tick),
		.accept (accept)
	);

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps

module tb;
	import rssa_pkg::*;

	localparam int unsigned SLOTS = MAX_CHANNELS_DEF;
	localparam int unsigned CYCLE_LIMIT = 400000;

	// Mirrors the sweep: phase, slot, dwell count and both per-slot stores.
	class sweep_scoreboard;
		logic [7:0]  first_ch;
		logic [7:0]  last_ch;
		logic [7:0]  setting;
		bit          measuring;
		int unsigned slot_now;
		logic [7:0]  taken;
		logic [7:0]  avg_lvl [SLOTS];
		logic [7:0]  peak_lvl [SLOTS];
		out_word_t   expected_q [$];
		int unsigned errors;
		int unsigned ticks;
		int unsigned retunes;
		int unsigned wraps;
		int unsigned dwells;
		int unsigned reg_writes;

		function new();
			first_ch = FIRST_CHANNEL_RST;
			last_ch = LAST_CHANNEL_RST;
			setting = SAMPLE_SETTING_RST;
			measuring = 1'b0;
			slot_now = 0;
			taken = '0;
			foreach (avg_lvl[i]) begin
				avg_lvl[i] = '0;
				peak_lvl[i] = '0;
			end
			errors = 0;
			ticks = 0;
			retunes = 0;
			wraps = 0;
			dwells = 0;
			reg_writes = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [7:0] val);
			reg_writes++;
			case (idx)
				REG_FIRST_CHANNEL: first_ch = val;
				REG_LAST_CHANNEL: last_ch = val;
				REG_SAMPLE_SETTING: setting = val;
				default: ;
			endcase
		endfunction

		function int unsigned span_now();
			int span;
			span = int'(last_ch) - int'(first_ch) + 1;
			if (span < 1)
				span = 1;
			if (span > int'(SLOTS))
				span = SLOTS;
			return span;
		endfunction

		// The setting is signed; 0x80 reads as -128 and so gives 128 samples.
		function int unsigned dwell_limit();
			int lim;
			lim = int'($signed(setting));
			if (lim < 0)
				lim = -lim;
			if (lim == 0)
				lim = 1;
			return lim;
		endfunction

		function void note_tick(in_word_t word);
			out_word_t   exp;
			logic [7:0]  lvl;
			int unsigned mix;
			exp = '0;
			ticks++;
			if (!measuring) begin
				taken = '0;
				slot_now = slot_now + 1;
				if (slot_now >= span_now()) begin
					slot_now = 0;
					exp.sweep_wrapped = 1'b1;
					wraps++;
				end
				if (setting != 8'd0)
					peak_lvl[slot_now] = '0;
				measuring = 1'b1;
				exp.retune = 1'b1;
				retunes++;
			end else begin
				lvl = word.raw_level ^ LEVEL_OFFSET;
				mix = lvl + 9 * avg_lvl[slot_now];
				avg_lvl[slot_now] = 8'(mix / 10);
				if (lvl > peak_lvl[slot_now])
					peak_lvl[slot_now] = lvl;
				taken = taken + 8'd1;
				if (taken >= dwell_limit()) begin
					measuring = 1'b0;
					exp.dwell_done = 1'b1;
					dwells++;
				end
			end
			exp.slot_index = 7'(slot_now);
			exp.radio_channel = first_ch + 8'(slot_now);
			exp.smoothed_level = avg_lvl[slot_now];
			exp.peak_level = peak_lvl[slot_now];
			expected_q.push_back(exp);
		endfunction

		function void check_result(out_word_t got);
			out_word_t exp;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("result word with none expected: slot %0d retune %0d",
						got.slot_index, got.retune);
				return;
			end
			exp = expected_q.pop_front();
			if (got.retune !== exp.retune || got.slot_index !== exp.slot_index ||
					got.radio_channel !== exp.radio_channel ||
					got.smoothed_level !== exp.smoothed_level ||
					got.peak_level !== exp.peak_level || got.dwell_done !== exp.dwell_done ||
					got.sweep_wrapped !== exp.sweep_wrapped) begin
				errors++;
				if (errors <= 10) begin
					$display("mismatch expected: rt %0d slot %0d ch %0d avg %0d pk %0d dn %0d wr %0d",
						exp.retune, exp.slot_index, exp.radio_channel, exp.smoothed_level,
						exp.peak_level, exp.dwell_done, exp.sweep_wrapped);
					$display("         got:      rt %0d slot %0d ch %0d avg %0d pk %0d dn %0d wr %0d",
						got.retune, got.slot_index, got.radio_channel, got.smoothed_level,
						got.peak_level, got.dwell_done, got.sweep_wrapped);
				end
			end
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int unsigned send_idle;
	int unsigned recv_idle;
	int unsigned cycles;
	sweep_scoreboard sb;
	logic [7:0] corner_levels [12] = '{8'h00, 8'hFF, 8'h7F, 8'h80, 8'h01, 8'hFE,
		8'h55, 8'hAA, 8'hFF, 8'h00, 8'h80, 8'h7F};

	rssa_cfg_if cfg_bus ();
	rssa_in_if  tick_bus ();
	rssa_out_if res_bus ();

	rssi_sweep_averager i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.sample (tick_bus),
		.result (res_bus)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("run exceeded %0d cycles with %0d words outstanding", CYCLE_LIMIT,
				sb.pending());
			$display("TEST FAILED");
			$finish;
		end
	end

	// Result side: random back-pressure, and every accepted word is checked.
	always @(posedge clk) begin
		if (arst_n && res_bus.valid && res_bus.ready)
			sb.check_result(res_bus.data);
		res_bus.ready <= (recv_idle == 0) || ($urandom_range(99) >= recv_idle);
	end

	task send_tick(input logic [7:0] lvl);
		in_word_t word;
		word.raw_level = lvl;
		while (send_idle != 0 && $urandom_range(99) < send_idle) begin
			tick_bus.valid <= 1'b0;
			@(posedge clk);
		end
		tick_bus.valid <= 1'b1;
		tick_bus.data <= word;
		do @(posedge clk); while (!tick_bus.ready);
		sb.note_tick(word);
	endtask

	// Valid is left high so back-to-back writes need no gap; program_sweep lowers it.
	task write_reg(input cfg_idx_t idx, input logic [7:0] val);
		cfg_bus.valid <= 1'b1;
		cfg_bus.data.index <= idx;
		cfg_bus.data.data <= val;
		do @(posedge clk); while (!cfg_bus.ready);
		sb.write_reg(idx, val);
	endtask

	task program_sweep(input bit [2:0] which, input logic [7:0] f, input logic [7:0] l,
			input logic [7:0] s);
		if (which[0])
			write_reg(REG_FIRST_CHANNEL, f);
		if (which[1])
			write_reg(REG_LAST_CHANNEL, l);
		if (which[2])
			write_reg(REG_SAMPLE_SETTING, s);
		cfg_bus.valid <= 1'b0;
	endtask

	// Registers may only change once every tick in flight has produced its word.
	task wait_idle();
		tick_bus.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function logic [7:0] pick_level();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h7F;
			3: return 8'h80;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task random_setup();
		logic [7:0] f;
		logic [7:0] l;
		logic [7:0] s;
		int unsigned k;
		case ($urandom_range(5))
			0: f = 8'd0;
			1: f = 8'd255;
			default: f = 8'($urandom_range(255));
		endcase
		// Mostly short sweeps so that the slot wraps often.
		case ($urandom_range(7))
			0: l = 8'd0;
			1: l = 8'd255;
			2: l = 8'($urandom_range(255));
			default: begin
				k = f + $urandom_range(7);
				l = (k > 255) ? 8'd255 : 8'(k);
			end
		endcase
		case ($urandom_range(13))
			0: s = 8'd0;
			1: s = 8'd127;
			2: s = 8'h80;
			3: s = 8'h81;
			4: s = 8'hFF;
			5: s = 8'd1;
			default: s = 8'($urandom_range(6)) - 8'd3;
		endcase
		program_sweep(3'($urandom_range(1, 7)), f, l, s);
	endtask

	initial begin
		int mode;
		int seg;
		int n;
		logic [7:0] f;
		clk = 1'b0;
		arst_n = 1'b0;
		cycles = 0;
		cfg_bus.valid = 1'b0;
		cfg_bus.data = '0;
		tick_bus.valid = 1'b0;
		tick_bus.data = '0;
		res_bus.ready = 1'b0;
		sb = new();
		send_idle = 19;
		recv_idle = 73;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: one sample per slot and the peak is never cleared.
		for (n = 0; n < 6; n++)
			send_tick(corner_levels[n]);
		wait_idle();
		// A span above the store size is clamped; two samples per slot.
		program_sweep(3'b111, 8'd0, 8'd255, 8'hFE);
		for (n = 6; n < 12; n++)
			send_tick(corner_levels[n]);
		wait_idle();
		// Lowering the sample count mid-dwell ends the dwell on the next sample.
		program_sweep(3'b100, 8'd0, 8'd0, 8'hFD);
		send_tick(8'h12);
		send_tick(8'h80);
		wait_idle();
		program_sweep(3'b100, 8'd0, 8'd0, 8'd1);
		send_tick(8'h7F);
		wait_idle();
		// Last channel below the first gives a single-slot sweep.
		program_sweep(3'b011, 8'd250, 8'd3, 8'd0);
		send_tick(8'hFF);
		send_tick(8'h00);
		send_tick(8'h01);
		send_tick(8'hC0);

		for (mode = 0; mode < 3; mode++) begin
			wait_idle();
			case (mode)
				0: begin
					send_idle = 19;
					recv_idle = 73;
				end
				1: begin
					send_idle = 73;
					recv_idle = 19;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			for (seg = 0; seg < 8; seg++) begin
				wait_idle();
				if (seg == 0 && mode < 2) begin
					// One full dwell at the longest sample counts.
					f = 8'($urandom_range(250));
					program_sweep(3'b111, f, f + 8'($urandom_range(1, 3)),
						(mode == 0) ? 8'h80 : 8'd127);
					n = 135;
				end else begin
					random_setup();
					n = $urandom_range(15, 45);
				end
				repeat (n) send_tick(pick_level());
			end
		end
		wait_idle();

		$display("%0d ticks over %0d register writes: %0d retunes, %0d sweep wraps, %0d dwells",
			sb.ticks, sb.reg_writes, sb.retunes, sb.wraps, sb.dwells);
		$display("%0d mismatches, %0d words still expected", sb.errors, sb.pending());
		if (sb.errors == 0 && sb.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

>>> sim.f
rtl/rssa_pkg.sv
rtl/rssa_if.sv
rtl/rssa_ram.sv
rtl/rssa_ctrl.sv
rtl/rssa_datapath.sv
rtl/rssi_sweep_averager.sv
test/tb.sv
